// File: design/rrtsd_pkg.sv
// ----------------------------------------------------------------------------
// rrtsd_pkg: shared definitions for the round robin task scheduler
// Field widths, event kind codes and the result type of the shared
// arithmetic unit.
// ----------------------------------------------------------------------------
package rrtsd_pkg;

   // Default number of scheduled tasks.
   localparam int TASK_COUNT_DEF = 8;

   // Tick counter and wake time width.
   localparam int WORD_W = 32;

   // Field widths of the stream ports.
   localparam int KIND_W     = 2;
   localparam int NEXT_W     = 4;
   localparam int MASK_W     = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   // Event kinds.
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BLOCK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_YIELD = 2'd2;

   // Outputs of the shared adder and comparator.
   typedef struct packed {
      logic [WORD_W-1:0] sum;
      logic              eq;
   } alu_res_type;

endpackage

// File: design/round_robin_task_scheduler_with_delays.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_with_delays: round robin scheduler with delays
// Keeps a tick counter, a wake time and a ready flag per task, and picks the
// next running task round robin on every tick, block or yield event.
// ----------------------------------------------------------------------------
// Usage:
// Each request transaction carries one event: req_tuser holds the kind
// (tick, block the running task, or yield) and req_tdata the delay in ticks
// used by a block. Each event produces exactly one response transaction
// with the chosen task, the ready mask and the tick count after the event.
// A chosen task equal to TASK_COUNT means no task is ready (idle).
//
// Work is done by a small sequencer around one shared adder/comparator and
// a wake time RAM. After acceptance, a tick increments the counter, makes
// one RAM compare per task, searches round robin over up to N slots and
// loads the result. A block writes the wake time and clears the running
// task's ready flag, a yield goes straight to the search, an unused kind
// only loads the result; N is TASK_COUNT. The search checks one slot per
// cycle. The block accepts a new event only when the sequencer is idle.
//
// Reset (synchronous, active high) clears the tick counter, makes task 0
// the running task and marks all tasks ready. The response register holds
// its transaction while rsp_tready is low; the next event can be accepted
// and worked on meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_with_delays #(
   parameter int TASK_COUNT = rrtsd_pkg::TASK_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata: delay_ticks [31:0]
   input  logic [rrtsd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: kind [1:0]
   input  logic [rrtsd_pkg::KIND_W-1:0]      req_tuser,
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata: next_task [3:0], ready_mask [11:4], tick_now [43:12],
   // zero fill [47:44]
   output logic [rrtsd_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // Width of a RAM address or slot index, and of a task number that can
   // also hold the idle value TASK_COUNT.
   localparam int IDX_W  = $clog2(TASK_COUNT);
   localparam int TASK_W = $clog2(TASK_COUNT + 1);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TASK_COUNT - 1);
   localparam logic [TASK_W-1:0] IDLE_TASK = TASK_W'(TASK_COUNT);
   localparam int W = rrtsd_pkg::WORD_W;

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_INC    = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_BLOCK  = 3'd3;
   localparam logic [2:0] S_PSTART = 3'd4;
   localparam logic [2:0] S_PICK   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   // Control state.
   logic [2:0]            state_ff,   state_in;
   logic [W-1:0]          tick_ff,    tick_in;
   logic [TASK_W-1:0]     running_ff, running_in;
   logic [TASK_COUNT-1:0] ready_ff,   ready_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Working registers of the sequencer.
   logic [rrtsd_pkg::KIND_W-1:0] kind_ff;
   logic [W-1:0]                 delay_ff;
   logic [IDX_W-1:0]             scan_ff, scan_in;
   logic [IDX_W-1:0]             pidx_ff, pidx_in;
   logic [IDX_W-1:0]             pcnt_ff, pcnt_in;

   // Response register.
   logic [rrtsd_pkg::NEXT_W-1:0] rsp_task_ff;
   logic [rrtsd_pkg::MASK_W-1:0] rsp_mask_ff;
   logic [W-1:0]                 rsp_tick_ff;
   logic                         rsp_load;

   // Shared unit and wake time RAM.
   logic [W-1:0]           alu_a, alu_b;
   rrtsd_pkg::alu_res_type alu_res;
   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [W-1:0]           ram_rd_data;

   logic             req_fire;
   logic             running_valid;
   logic [IDX_W-1:0] running_idx;
   logic [IDX_W-1:0] scan_next;
   logic [IDX_W-1:0] pidx_next;
   logic [IDX_W-1:0] start_idx;

   assign req_tready    = (state_ff == S_IDLE);
   assign req_fire      = req_tvalid && req_tready;
   assign running_valid = (running_ff < IDLE_TASK);
   assign running_idx   = running_ff[IDX_W-1:0];
   assign scan_next     = (scan_ff == LAST_IDX) ? '0 : scan_ff + IDX_W'(1);
   assign pidx_next     = (pidx_ff == LAST_IDX) ? '0 : pidx_ff + IDX_W'(1);

   // The search begins after the running task, or at task 0 when idle.
   always_comb begin
      if (!running_valid || running_idx == LAST_IDX) begin
         start_idx = '0;
      end else begin
         start_idx = running_idx + IDX_W'(1);
      end
   end

   // Operand selection for the shared adder and comparator.
   always_comb begin
      unique case (state_ff)
         S_INC: begin
            alu_a = tick_ff;
            alu_b = W'(1);
         end
         S_SCAN: begin
            alu_a = ram_rd_data;
            alu_b = tick_ff;
         end
         S_BLOCK: begin
            alu_a = tick_ff;
            alu_b = delay_ff;
         end
         default: begin
            alu_a = tick_ff;
            alu_b = '0;
         end
      endcase
   end

   rrtsd_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   // The scan reads slot 0 while the counter increments, then one slot
   // ahead of the compare on each cycle.
   assign ram_rd_addr = (state_ff == S_SCAN) ? scan_next : '0;
   assign ram_wr_en   = (state_ff == S_BLOCK) && running_valid;

   rrtsd_ram #(
      .WIDTH (W),
      .DEPTH (TASK_COUNT)
   ) u_wake_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (running_idx),
      .wr_data (alu_res.sum),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      running_in   = running_ff;
      ready_in     = ready_ff;
      scan_in      = scan_ff;
      pidx_in      = pidx_ff;
      pcnt_in      = pcnt_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  rrtsd_pkg::KIND_TICK:  state_in = S_INC;
                  rrtsd_pkg::KIND_BLOCK: state_in = S_BLOCK;
                  rrtsd_pkg::KIND_YIELD: state_in = S_PSTART;
                  // The unused kind changes nothing and reports the state.
                  default:               state_in = S_DONE;
               endcase
            end
         end
         S_INC: begin
            tick_in  = alu_res.sum;
            scan_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // A task whose wake time equals the new count becomes ready.
            if (alu_res.eq) begin
               ready_in[scan_ff] = 1'b1;
            end
            scan_in = scan_next;
            if (scan_ff == LAST_IDX) begin
               state_in = S_PSTART;
            end
         end
         S_BLOCK: begin
            // A block while idle blocks nothing and acts as a yield.
            if (running_valid) begin
               ready_in[running_idx] = 1'b0;
            end
            state_in = S_PSTART;
         end
         S_PSTART: begin
            pidx_in  = start_idx;
            pcnt_in  = '0;
            state_in = S_PICK;
         end
         S_PICK: begin
            if (ready_ff[pidx_ff]) begin
               running_in = TASK_W'(pidx_ff);
               state_in   = S_DONE;
            end else if (pcnt_ff == LAST_IDX) begin
               running_in = IDLE_TASK;
               state_in   = S_DONE;
            end else begin
               pidx_in = pidx_next;
               pcnt_in = pcnt_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            // Load the response once the register is free or being emptied.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         running_ff   <= '0;
         ready_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         running_ff   <= running_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      pidx_ff <= pidx_in;
      pcnt_ff <= pcnt_in;
      if (req_fire) begin
         kind_ff  <= req_tuser;
         delay_ff <= req_tdata[W-1:0];
      end
      if (rsp_load) begin
         rsp_task_ff <= rrtsd_pkg::NEXT_W'(running_ff);
         rsp_mask_ff <= rrtsd_pkg::MASK_W'(ready_ff);
         rsp_tick_ff <= tick_ff;
      end
   end

   // The latched kind is kept for visibility of the event in flight; it
   // selects nothing after the dispatch from the idle state.
   logic kind_is_block;
   assign kind_is_block = (kind_ff == rrtsd_pkg::KIND_BLOCK);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      (rrtsd_pkg::RSP_DATA_W - rrtsd_pkg::NEXT_W - rrtsd_pkg::MASK_W - W)'(kind_is_block & 1'b0),
      rsp_tick_ff, rsp_mask_ff, rsp_task_ff
   };

endmodule

// File: design/rrtsd_ram.sv
// ----------------------------------------------------------------------------
// rrtsd_ram: generic single write port RAM with a registered read
// One write and one read per cycle; read data is registered and appears in the cycle after its address.
// ----------------------------------------------------------------------------
module rrtsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/rrtsd_alu.sv
// ----------------------------------------------------------------------------
// rrtsd_alu: shared adder and equality comparator
// Serves the tick increment, the wake time compare and the wake time sum.
// ----------------------------------------------------------------------------
module rrtsd_alu (
   input  logic [rrtsd_pkg::WORD_W-1:0] op_a,
   input  logic [rrtsd_pkg::WORD_W-1:0] op_b,
   output rrtsd_pkg::alu_res_type       res
);

   always_comb begin
      // The sum wraps modulo two to the word width.
      res.sum = op_a + op_b;
      res.eq  = (op_a == op_b);
   end

endmodule
